// ===== hdl/chc_pkg.sv =====
// Shared types and constants of the climate hysteresis controller.
package chc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int TARGET_W  = 16;
    localparam int DB_WORD_W = 48;
    localparam int MODE_W    = 6;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = DB_WORD_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COOL_TARGET    = 8'd0,
        REG_HEAT_TARGET    = 8'd1,
        REG_DEHUMID_TARGET = 8'd2,
        REG_HUMID_TARGET   = 8'd3,
        REG_CO2_TARGET     = 8'd4,
        REG_DEADBAND       = 8'd5,
        REG_MODE_FLAGS     = 8'd6,
        REG_ENABLE         = 8'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_CONV = 2'd0,
        MODE_HP_O = 2'd1,
        MODE_HP_B = 2'd2,
        MODE_NONE = 2'd3
    } hvac_mode_t;

    localparam logic [DB_WORD_W-1:0] DEADBAND_RESET = 48'h0032_001E_000A;

    // Relay patterns and clear masks
    localparam logic [7:0] HVAC_COOL_CONV  = 8'h0C;
    localparam logic [7:0] HVAC_COOL_HPB   = 8'h1C;
    localparam logic [7:0] HVAC_HEAT_CONV  = 8'h14;
    localparam logic [7:0] HVAC_HEAT_HPO   = 8'h1C;
    localparam logic [7:0] HVAC_HEAT_HPB   = 8'h0C;
    localparam logic [7:0] HVAC_COOL_CLR   = 8'hF3;
    localparam logic [7:0] HVAC_COOL_CLR_B = 8'hE3;
    localparam logic [7:0] HVAC_HEAT_CLR   = 8'hEF;
    localparam logic [7:0] HVAC_HEAT_CLR_O = 8'hE7;
    localparam logic [7:0] HVAC_HEAT_CLR_B = 8'hF7;
    localparam logic [7:0] HVAC_COMP_BIT   = 8'h08;

    typedef struct packed {
        logic [TARGET_W-1:0] cool_target;
        logic [TARGET_W-1:0] heat_target;
        logic [TARGET_W-1:0] dehumid_target;
        logic [TARGET_W-1:0] humid_target;
        logic [TARGET_W-1:0] co2_target;
        logic [TARGET_W-1:0] temp_db;
        logic [TARGET_W-1:0] humid_db;
        logic [TARGET_W-1:0] co2_db;
        logic                link;
        logic                co2_cool_lock;
        logic                co2_dehum_lock;
        logic                fuzzy;
        hvac_mode_t          mode;
        logic                enable;
    } ctrl_cfg_t;

    typedef struct packed {
        logic       cooler;
        logic       heater;
        logic       dehumid;
        logic       humid;
        logic       co2;
        logic [7:0] hvac;
    } ctrl_state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] temp;
        logic [SAMPLE_W-1:0] humid;
        logic [SAMPLE_W-1:0] co2;
        logic                day;
    } sample_t;

endpackage

// ===== hdl/chc_if.sv =====
// Channel interfaces: sensor samples, controller results, register writes.
interface chc_sample_if;
    logic                         valid;
    logic                         ready;
    logic [chc_pkg::SAMPLE_W-1:0] temp_now;
    logic [chc_pkg::SAMPLE_W-1:0] humid_now;
    logic [chc_pkg::SAMPLE_W-1:0] co2_now;
    logic                         daytime;

    modport source (output valid, temp_now, humid_now, co2_now, daytime, input ready);
    modport sink (input valid, temp_now, humid_now, co2_now, daytime, output ready);
endinterface

interface chc_result_if;
    logic       valid;
    logic       ready;
    logic       cooler_on;
    logic       heater_on;
    logic       dehumidifier_on;
    logic       humidifier_on;
    logic       co2_valve_on;
    logic [7:0] hvac_relays;

    modport source (output valid, cooler_on, heater_on, dehumidifier_on, humidifier_on,
                    co2_valve_on, hvac_relays, input ready);
    modport sink (input valid, cooler_on, heater_on, dehumidifier_on, humidifier_on,
                  co2_valve_on, hvac_relays, output ready);
endinterface

interface chc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [chc_pkg::CFG_IDX_W-1:0]  index;
    logic [chc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/climate_hysteresis_controller_top.sv =====
// Climate hysteresis controller: sample register, state/result register, config registers.
//
// Each sample set (temperature, humidity, CO2, daytime) is taken into an input
// register; once the result slot is free, the hysteresis logic updates the device
// states and relay byte in the state register, which form the result. One sample
// set is accepted every cycle while the result is not stalled; a stalled result
// holds the input side only once the input register is also full. Register writes
// take effect at once and are meant for times when no sample is in flight. Only the
// low SAMPLE_BITS bits (at most SAMPLE_W) of each reading are used.
module climate_hysteresis_controller_top
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    chc_sample_if.sink   sample,
    chc_result_if.source result,
    chc_cfg_if.sink      cfg
);
    import chc_pkg::*;

    localparam int KEEP_W = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

    ctrl_cfg_t   cfg_cur;
    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    sample_t     smp;

    logic              in_valid_reg;
    logic [KEEP_W-1:0] temp_reg;
    logic [KEEP_W-1:0] humid_reg;
    logic [KEEP_W-1:0] co2_reg;
    logic              day_reg;
    logic              out_valid_reg;
    logic              advance;

    chc_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    assign smp.temp  = SAMPLE_W'(temp_reg);
    assign smp.humid = SAMPLE_W'(humid_reg);
    assign smp.co2   = SAMPLE_W'(co2_reg);
    assign smp.day   = day_reg;

    chc_step u_step
    (
        .cfg (cfg_cur),
        .cur (state_reg),
        .smp (smp),
        .nxt (state_next)
    );

    // Move the held sample into the state register when the result slot frees.
    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (sample.ready)
                in_valid_reg <= sample.valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            temp_reg  <= sample.temp_now[KEEP_W-1:0];
            humid_reg <= sample.humid_now[KEEP_W-1:0];
            co2_reg   <= sample.co2_now[KEEP_W-1:0];
            day_reg   <= sample.daytime;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.cooler_on       = state_reg.cooler;
    assign result.heater_on       = state_reg.heater;
    assign result.dehumidifier_on = state_reg.dehumid;
    assign result.humidifier_on   = state_reg.humid;
    assign result.co2_valve_on    = state_reg.co2;
    assign result.hvac_relays     = state_reg.hvac;

endmodule

// ===== hdl/chc_cfg_regs.sv =====
// Configuration register file with field unpacking.
module chc_cfg_regs
(
    input  logic              clk,
    input  logic              rst_n,
    chc_cfg_if.sink           cfg,
    output chc_pkg::ctrl_cfg_t cfg_out
);
    import chc_pkg::*;

    logic [TARGET_W-1:0]  cool_target_reg;
    logic [TARGET_W-1:0]  heat_target_reg;
    logic [TARGET_W-1:0]  dehumid_target_reg;
    logic [TARGET_W-1:0]  humid_target_reg;
    logic [TARGET_W-1:0]  co2_target_reg;
    logic [DB_WORD_W-1:0] deadband_reg;
    logic [MODE_W-1:0]    mode_flags_reg;
    logic                 enable_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cool_target_reg    <= '0;
            heat_target_reg    <= '0;
            dehumid_target_reg <= '0;
            humid_target_reg   <= '0;
            co2_target_reg     <= '0;
            deadband_reg       <= DEADBAND_RESET;
            mode_flags_reg     <= '0;
            enable_reg         <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (reg_index_t'(cfg.index))
                REG_COOL_TARGET:    cool_target_reg    <= cfg.data[TARGET_W-1:0];
                REG_HEAT_TARGET:    heat_target_reg    <= cfg.data[TARGET_W-1:0];
                REG_DEHUMID_TARGET: dehumid_target_reg <= cfg.data[TARGET_W-1:0];
                REG_HUMID_TARGET:   humid_target_reg   <= cfg.data[TARGET_W-1:0];
                REG_CO2_TARGET:     co2_target_reg     <= cfg.data[TARGET_W-1:0];
                REG_DEADBAND:       deadband_reg       <= cfg.data[DB_WORD_W-1:0];
                REG_MODE_FLAGS:     mode_flags_reg     <= cfg.data[MODE_W-1:0];
                REG_ENABLE:         enable_reg         <= cfg.data[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        cfg_out.cool_target    = cool_target_reg;
        cfg_out.heat_target    = heat_target_reg;
        cfg_out.dehumid_target = dehumid_target_reg;
        cfg_out.humid_target   = humid_target_reg;
        cfg_out.co2_target     = co2_target_reg;
        cfg_out.temp_db        = deadband_reg[15:0];
        cfg_out.humid_db       = deadband_reg[31:16];
        cfg_out.co2_db         = deadband_reg[47:32];
        cfg_out.link           = mode_flags_reg[0];
        cfg_out.co2_cool_lock  = mode_flags_reg[1];
        cfg_out.co2_dehum_lock = mode_flags_reg[2];
        cfg_out.fuzzy          = mode_flags_reg[3];
        cfg_out.mode           = hvac_mode_t'(mode_flags_reg[5:4]);
        cfg_out.enable         = enable_reg;
    end

endmodule

// ===== hdl/chc_step.sv =====
// Next-state logic: temperature, humidity and CO2 hysteresis for one sample set.
module chc_step
(
    input  chc_pkg::ctrl_cfg_t   cfg,
    input  chc_pkg::ctrl_state_t cur,
    input  chc_pkg::sample_t     smp,
    output chc_pkg::ctrl_state_t nxt
);
    import chc_pkg::*;

    // Compares are rearranged so every operand stays non-negative.
    logic [17:0] temp_lim;
    logic [17:0] humid_lim;
    logic        temp_run;
    logic        humid_run;

    assign temp_lim  = 18'(cfg.heat_target) + 18'({cfg.temp_db, 1'b0});
    assign humid_lim = 18'(cfg.humid_target) + 18'({cfg.humid_db, 1'b0});
    assign temp_run  = !(18'(cfg.cool_target) < temp_lim);
    assign humid_run = !(18'(cfg.dehumid_target) < humid_lim);

    always_comb
    begin
        ctrl_state_t s;
        logic        blocked;
        s = cur;
        blocked = 1'b0;

        if (cfg.enable)
        begin
            // temperature
            if (temp_run)
            begin
                if (smp.day)
                begin
                    if (smp.temp >= cfg.cool_target)
                    begin
                        s.cooler = 1'b1;
                        case (cfg.mode)
                            MODE_CONV, MODE_HP_O: s.hvac = HVAC_COOL_CONV;
                            MODE_HP_B:            s.hvac = HVAC_COOL_HPB;
                            default:              ;
                        endcase
                    end
                    else if (17'(smp.temp) + 17'(cfg.temp_db) <= 17'(cfg.cool_target))
                    begin
                        s.cooler = 1'b0;
                        case (cfg.mode)
                            MODE_CONV, MODE_HP_O: s.hvac = s.hvac & HVAC_COOL_CLR;
                            MODE_HP_B:            s.hvac = s.hvac & HVAC_COOL_CLR_B;
                            default:              ;
                        endcase
                    end

                    if (smp.temp <= cfg.heat_target)
                    begin
                        s.heater = 1'b1;
                        case (cfg.mode)
                            MODE_CONV: s.hvac = HVAC_HEAT_CONV;
                            MODE_HP_O: s.hvac = HVAC_HEAT_HPO;
                            MODE_HP_B: s.hvac = HVAC_HEAT_HPB;
                            default:   ;
                        endcase
                    end
                    else if (17'(smp.temp) >= 17'(cfg.heat_target) + 17'(cfg.temp_db))
                    begin
                        s.heater = 1'b0;
                        case (cfg.mode)
                            MODE_CONV: s.hvac = s.hvac & HVAC_HEAT_CLR;
                            MODE_HP_O: s.hvac = s.hvac & HVAC_HEAT_CLR_O;
                            MODE_HP_B: s.hvac = s.hvac & HVAC_HEAT_CLR_B;
                            default:   ;
                        endcase
                    end
                end
                if (cfg.link)
                    s.dehumid = s.cooler;
            end

            // humidity
            if (humid_run)
            begin
                if (smp.day)
                begin
                    if (smp.humid >= cfg.dehumid_target)
                        s.dehumid = 1'b1;
                    else if (17'(smp.humid) + 17'(cfg.humid_db)
                             <= 17'(cfg.dehumid_target))
                        s.dehumid = 1'b0;

                    if (smp.humid <= cfg.humid_target)
                        s.humid = 1'b1;
                    else if (17'(smp.humid) >= 17'(cfg.humid_target) + 17'(cfg.humid_db))
                        s.humid = 1'b0;
                end
                if (cfg.link)
                    s.cooler = s.dehumid;
            end

            // CO2
            if (smp.day && !cfg.fuzzy)
            begin
                blocked = (cfg.co2_dehum_lock && s.dehumid) ||
                          (cfg.co2_cool_lock && (s.cooler || ((s.hvac & HVAC_COMP_BIT) != '0)));
                if (smp.co2 <= cfg.co2_target)
                    s.co2 = !blocked;
                else if (17'(smp.co2) >= 17'(cfg.co2_target) + 17'(cfg.co2_db))
                    s.co2 = 1'b0;
            end
        end

        nxt = s;
    end

endmodule

// ===== hdl/chc_checker.sv =====
// Port-level checks of the climate hysteresis controller, bound to the top level.
module chc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       cooler_on,
    input logic       heater_on,
    input logic       dehumidifier_on,
    input logic       humidifier_on,
    input logic       co2_valve_on,
    input logic [7:0] hvac_relays
);
    logic [12:0] payload;

    assign payload = {cooler_on, heater_on, dehumidifier_on, humidifier_on,
                      co2_valve_on, hvac_relays};

    // Stalled result keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(payload))
        else $error("result changed while stalled");

    // Device states move only together with a new result.
    a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> $stable(payload))
        else $error("state changed without a result");

    // A fresh result after an empty slot comes from a sample transfer through the input register.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a sample transfer");

    // Input side stays open while the result slot is free.
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with free result slot");

endmodule

bind climate_hysteresis_controller_top chc_checker u_chc_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (sample.valid),
    .in_ready        (sample.ready),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .cooler_on       (result.cooler_on),
    .heater_on       (result.heater_on),
    .dehumidifier_on (result.dehumidifier_on),
    .humidifier_on   (result.humidifier_on),
    .co2_valve_on    (result.co2_valve_on),
    .hvac_relays     (result.hvac_relays)
);

// ===== verif/climate_hysteresis_controller_top_test.sv =====
// Self-checking testbench of the climate hysteresis controller top level.
`timescale 1ns / 100ps

module climate_hysteresis_controller_top_test;
    import chc_pkg::*;

    localparam int NUM_REGS        = REG_ENABLE + 1;
    localparam int CFG_IDX_MAX     = (1 << CFG_IDX_W) - 1;
    localparam int PIPE_LAT        = 2;
    localparam int DRAIN_CYCLES    = 8;
    localparam int ITEMS_PER_PHASE = 500;
    localparam int HOLD_CYCLES     = 200;
    localparam int HOLD_AT_ITEM    = 100;
    localparam int MAX_REPORTS     = 10;
    localparam int N_DIR           = 44;
    localparam longint TIMEOUT_NS  = 1_000_000;

    localparam logic [MODE_W-1:0] MF_LINK       = 6'b00_0001;
    localparam logic [MODE_W-1:0] MF_COOL_LOCK  = 6'b00_0010;
    localparam logic [MODE_W-1:0] MF_DEHUM_LOCK = 6'b00_0100;
    localparam logic [MODE_W-1:0] MF_FUZZY      = 6'b00_1000;
    localparam logic [CFG_IDX_W-1:0] IDX_OUT_OF_RANGE = 8'hFF;

    localparam sample_t     NO_SAMPLE = '0;
    localparam ctrl_state_t ALL_OFF   = '0;

    typedef enum logic {ROW_CFG, ROW_SMP} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        sample_t                smp;
        bit                     chk;
        ctrl_state_t            want;
    } row_t;

    logic clk;
    logic rst_n;

    chc_sample_if sample_ch();
    chc_result_if result_ch();
    chc_cfg_if    cfg_ch();

    climate_hysteresis_controller_top dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    ctrl_cfg_t   ctl_cfg;
    ctrl_state_t ctl_state;
    ctrl_state_t expected_outputs [$];

    int src_idle_pct;
    int snk_idle_pct;
    bit hold_req;
    int mism_count;
    int sets_sent;
    int results_checked;
    int reg_writes;
    int bad_writes;
    int holdoffs;

    // Result bits: {cooler, heater, dehumid, humid, co2}, then the relay byte.
    row_t dir_rows [N_DIR] = '{
        '{ROW_SMP, '0, '0, {16'd0, 16'd0, 16'd0, 1'b1}, 1'b1, {5'b00001, 8'h00}},
        '{ROW_SMP, '0, '0, {16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b1, ALL_OFF},
        '{ROW_SMP, '0, '0, {16'd0, 16'd0, 16'd0, 1'b0}, 1'b1, ALL_OFF},
        '{ROW_CFG, REG_COOL_TARGET, 48'd30000, NO_SAMPLE, 1'b0, ALL_OFF},
        '{ROW_CFG, REG_HEAT_TARGET, 48'd10000, NO_SAMPLE, 1'b0, ALL_OFF},
        '{ROW_CFG, REG_DEHUMID_TARGET, 48'd60000, NO_SAMPLE, 1'b0, ALL_OFF},
        '{ROW_CFG, REG_HUMID_TARGET, 48'd20000, NO_SAMPLE, 1'b0, ALL_OFF},
        '{ROW_CFG, REG_CO2_TARGET, 48'd1000, NO_SAMPLE, 1'b0, ALL_OFF},
        '{ROW_CFG, REG_DEADBAND, {16'd300, 16'd200, 16'd100}, NO_SAMPLE, 1'b0, ALL_OFF},
        '{ROW_SMP, '0, '0, {16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b1, {5'b10100, 8'h0C}},
        '{ROW_SMP, '0, '0, {16'd0, 16'd0, 16'd0, 1'b1}, 1'b1, {5'b01011, 8'h14}},
        '{ROW_SMP, '0, '0, {16'd30000, 16'd20000, 16'd1000, 1'b1}, 1'b0, ALL_OFF},
        '{ROW_SMP, '0, '0, {16'd29900, 16'd20200, 16'd1300, 1'b1}, 1'b0, ALL_OFF},
        '{ROW_SMP, '0, '0, {16'd10000, 16'd60000, 16'd0, 1'b1}, 1'b0, ALL_OFF},
        '{ROW_SMP, '0, '0, {16'd10100, 16'd59800, 16'd1000, 1'b1}, 1'b0, ALL_OFF},
        '{ROW_CFG, REG_MODE_FLAGS, 48'({MODE_HP_O, 4'b0000}), NO_SAMPLE, 1'b0, ALL_OFF},
        '{ROW_SMP, '0, '0, {16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b0, ALL_OFF},
        '{ROW_SMP, '0, '0, {16'd0, 16'd0, 16'd0, 1'b1}, 1'b0, ALL_OFF},
        '{ROW_CFG, REG_MODE_FLAGS, 48'({MODE_HP_B, 4'b0000}), NO_SAMPLE, 1'b0, ALL_OFF},
        '{ROW_SMP, '0, '0, {16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b0, ALL_OFF},
        '{ROW_SMP, '0, '0, {16'd0, 16'd0, 16'd0, 1'b1}, 1'b0, ALL_OFF},
        '{ROW_CFG, REG_MODE_FLAGS, 48'({MODE_NONE, 4'b0000}), NO_SAMPLE, 1'b0, ALL_OFF},
        '{ROW_SMP, '0, '0, {16'hFFFF, 16'd0, 16'd0, 1'b1}, 1'b0, ALL_OFF},
        '{ROW_CFG, REG_MODE_FLAGS,
          48'({MODE_HP_O, 4'b0000} | MF_LINK | MF_COOL_LOCK | MF_DEHUM_LOCK),
          NO_SAMPLE, 1'b0, ALL_OFF},
        '{ROW_SMP, '0, '0, {16'd40000, 16'd0, 16'd0, 1'b1}, 1'b0, ALL_OFF},
        '{ROW_SMP, '0, '0, {16'd40000, 16'd65000, 16'd0, 1'b1}, 1'b0, ALL_OFF},
        '{ROW_SMP, '0, '0, {16'd0, 16'd0, 16'd0, 1'b1}, 1'b0, ALL_OFF},
        '{ROW_SMP, '0, '0, {16'd40000, 16'd65000, 16'd0, 1'b0}, 1'b0, ALL_OFF},
        '{ROW_CFG, REG_MODE_FLAGS, 48'(MF_FUZZY), NO_SAMPLE, 1'b0, ALL_OFF},
        '{ROW_SMP, '0, '0, {16'd0, 16'd0, 16'd0, 1'b1}, 1'b0, ALL_OFF},
        '{ROW_CFG, REG_COOL_TARGET, 48'd10199, NO_SAMPLE, 1'b0, ALL_OFF},
        '{ROW_SMP, '0, '0, {16'hFFFF, 16'd30000, 16'd5000, 1'b1}, 1'b0, ALL_OFF},
        '{ROW_CFG, REG_COOL_TARGET, 48'd10200, NO_SAMPLE, 1'b0, ALL_OFF},
        '{ROW_SMP, '0, '0, {16'hFFFF, 16'd30000, 16'd5000, 1'b1}, 1'b0, ALL_OFF},
        '{ROW_CFG, REG_ENABLE, 48'd0, NO_SAMPLE, 1'b0, ALL_OFF},
        '{ROW_SMP, '0, '0, {16'd0, 16'd0, 16'd0, 1'b1}, 1'b0, ALL_OFF},
        '{ROW_CFG, IDX_OUT_OF_RANGE, '1, NO_SAMPLE, 1'b0, ALL_OFF},
        '{ROW_SMP, '0, '0, {16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b0, ALL_OFF},
        '{ROW_CFG, REG_ENABLE, 48'd1, NO_SAMPLE, 1'b0, ALL_OFF},
        '{ROW_SMP, '0, '0, {16'd0, 16'd0, 16'd0, 1'b1}, 1'b0, ALL_OFF},
        '{ROW_CFG, REG_DEADBAND, '1, NO_SAMPLE, 1'b0, ALL_OFF},
        '{ROW_SMP, '0, '0, {16'd30000, 16'd20000, 16'hFFFF, 1'b1}, 1'b0, ALL_OFF},
        '{ROW_CFG, REG_DEADBAND, '0, NO_SAMPLE, 1'b0, ALL_OFF},
        '{ROW_SMP, '0, '0, {16'd30000, 16'd20000, 16'd1000, 1'b1}, 1'b0, ALL_OFF}
    };

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Device states and relay byte after one sensor set.
    function automatic ctrl_state_t next_device_state(ctrl_state_t st, ctrl_cfg_t c,
                                                      sample_t s);
        ctrl_state_t n;
        longint t, h, o, ct, ht, dt, hu, ot, tdb, hdb, cdb;
        bit blocked;
        n = st;
        if (!c.enable)
            return n;
        t = s.temp;
        h = s.humid;
        o = s.co2;
        ct = c.cool_target;
        ht = c.heat_target;
        dt = c.dehumid_target;
        hu = c.humid_target;
        ot = c.co2_target;
        tdb = c.temp_db;
        hdb = c.humid_db;
        cdb = c.co2_db;

        // Skip a stage, link included, when its targets overlap the deadbands.
        if (!(ct < ht + 2 * tdb))
        begin
            if (s.day)
            begin
                if (t >= ct)
                begin
                    n.cooler = 1'b1;
                    case (c.mode)
                        MODE_CONV, MODE_HP_O: n.hvac = HVAC_COOL_CONV;
                        MODE_HP_B:            n.hvac = HVAC_COOL_HPB;
                        default:              ;
                    endcase
                end
                else if (t <= ct - tdb)
                begin
                    n.cooler = 1'b0;
                    case (c.mode)
                        MODE_CONV, MODE_HP_O: n.hvac &= HVAC_COOL_CLR;
                        MODE_HP_B:            n.hvac &= HVAC_COOL_CLR_B;
                        default:              ;
                    endcase
                end
                if (t <= ht)
                begin
                    n.heater = 1'b1;
                    case (c.mode)
                        MODE_CONV: n.hvac = HVAC_HEAT_CONV;
                        MODE_HP_O: n.hvac = HVAC_HEAT_HPO;
                        MODE_HP_B: n.hvac = HVAC_HEAT_HPB;
                        default:   ;
                    endcase
                end
                else if (t >= ht + tdb)
                begin
                    n.heater = 1'b0;
                    case (c.mode)
                        MODE_CONV: n.hvac &= HVAC_HEAT_CLR;
                        MODE_HP_O: n.hvac &= HVAC_HEAT_CLR_O;
                        MODE_HP_B: n.hvac &= HVAC_HEAT_CLR_B;
                        default:   ;
                    endcase
                end
            end
            if (c.link)
                n.dehumid = n.cooler;
        end

        if (!(dt < hu + 2 * hdb))
        begin
            if (s.day)
            begin
                if (h >= dt)
                    n.dehumid = 1'b1;
                else if (h <= dt - hdb)
                    n.dehumid = 1'b0;
                if (h <= hu)
                    n.humid = 1'b1;
                else if (h >= hu + hdb)
                    n.humid = 1'b0;
            end
            if (c.link)
                n.cooler = n.dehumid;
        end

        if (s.day && !c.fuzzy)
        begin
            if (o <= ot)
            begin
                blocked = (c.co2_dehum_lock && n.dehumid) ||
                          (c.co2_cool_lock && (n.cooler || (n.hvac & HVAC_COMP_BIT) != 0));
                n.co2 = !blocked;
            end
            else if (o >= ot + cdb)
                n.co2 = 1'b0;
        end
        return n;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_COOL_TARGET:    ctl_cfg.cool_target = data[TARGET_W-1:0];
            REG_HEAT_TARGET:    ctl_cfg.heat_target = data[TARGET_W-1:0];
            REG_DEHUMID_TARGET: ctl_cfg.dehumid_target = data[TARGET_W-1:0];
            REG_HUMID_TARGET:   ctl_cfg.humid_target = data[TARGET_W-1:0];
            REG_CO2_TARGET:     ctl_cfg.co2_target = data[TARGET_W-1:0];
            REG_DEADBAND:       {ctl_cfg.co2_db, ctl_cfg.humid_db, ctl_cfg.temp_db} = data;
            REG_MODE_FLAGS:
            begin
                ctl_cfg.link = data[0];
                ctl_cfg.co2_cool_lock = data[1];
                ctl_cfg.co2_dehum_lock = data[2];
                ctl_cfg.fuzzy = data[3];
                ctl_cfg.mode = hvac_mode_t'(data[5:4]);
            end
            REG_ENABLE:         ctl_cfg.enable = data[0];
            default:            ;
        endcase
    endfunction

    function automatic string fmt_state(ctrl_state_t s);
        return $sformatf("cool=%b heat=%b dehum=%b hum=%b co2=%b hvac=%02h",
                         s.cooler, s.heater, s.dehumid, s.humid, s.co2, s.hvac);
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(2, 0))
            0:       return '0;
            1:       return '1;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly land around a threshold so that the hysteresis bands get exercised.
    function automatic logic [15:0] reading_near(logic [15:0] target, logic [15:0] db);
        int v;
        case ($urandom_range(5, 0))
            0:       return 16'($urandom);
            1:       return $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
            default:
            begin
                v = int'(target) - int'(db) - 2 + int'($urandom_range(2 * int'(db) + 4, 0));
                if (v < 0)
                    v = 0;
                if (v > 65535)
                    v = 65535;
                return 16'(v);
            end
        endcase
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        s.temp = reading_near($urandom_range(1, 0) ? ctl_cfg.cool_target : ctl_cfg.heat_target,
                              ctl_cfg.temp_db);
        s.humid = reading_near($urandom_range(1, 0) ? ctl_cfg.dehumid_target
                                                    : ctl_cfg.humid_target, ctl_cfg.humid_db);
        s.co2 = reading_near(ctl_cfg.co2_target, ctl_cfg.co2_db);
        s.day = ($urandom_range(99, 0) < 85);
        return s;
    endfunction

    task automatic report_failure(input string what);
        mism_count++;
        if (mism_count <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_sample(input sample_t s, input bit chk, input ctrl_state_t want);
        while ($urandom_range(99, 0) < src_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.temp_now <= s.temp;
        sample_ch.humid_now <= s.humid;
        sample_ch.co2_now <= s.co2;
        sample_ch.daytime <= s.day;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        ctl_state = next_device_state(ctl_state, ctl_cfg, s);
        expected_outputs.push_back(chk ? want : ctl_state);
        sets_sent++;
        @(negedge clk);
    endtask

    // Register writes only go out once the pipeline has drained.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        sample_ch.valid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(negedge clk);
        repeat (PIPE_LAT)
            @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        apply_reg(idx, data);
        reg_writes++;
        if (idx >= NUM_REGS)
            bad_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic randomize_settings();
        logic [CFG_DATA_W-1:0] vals [NUM_REGS];
        int tdb, hdb, ht, hu, ct, dt;
        bit wild;
        foreach (vals[i])
            vals[i] = 48'({$urandom, $urandom});
        wild = ($urandom_range(7, 0) == 0);
        if (wild)
        begin
            vals[REG_COOL_TARGET][15:0] = pick16();
            vals[REG_HEAT_TARGET][15:0] = pick16();
            vals[REG_DEHUMID_TARGET][15:0] = pick16();
            vals[REG_HUMID_TARGET][15:0] = pick16();
            vals[REG_CO2_TARGET][15:0] = pick16();
            vals[REG_DEADBAND] = {pick16(), pick16(), pick16()};
        end
        else
        begin
            tdb = $urandom_range(400, 0);
            hdb = $urandom_range(400, 0);
            ht = $urandom_range(40000, 0);
            hu = $urandom_range(40000, 0);
            // Now and then put the targets one count too close together.
            ct = ht + 2 * tdb + (($urandom_range(7, 0) == 0) ? -1 : $urandom_range(8000, 0));
            dt = hu + 2 * hdb + (($urandom_range(7, 0) == 0) ? -1 : $urandom_range(8000, 0));
            if (ct < 0)
                ct = 0;
            if (dt < 0)
                dt = 0;
            vals[REG_COOL_TARGET][15:0] = 16'(ct);
            vals[REG_HEAT_TARGET][15:0] = 16'(ht);
            vals[REG_DEHUMID_TARGET][15:0] = 16'(dt);
            vals[REG_HUMID_TARGET][15:0] = 16'(hu);
            vals[REG_DEADBAND] = {16'($urandom_range(400, 0)), 16'(hdb), 16'(tdb)};
            vals[REG_MODE_FLAGS][3] = ($urandom_range(3, 0) == 0);
            vals[REG_ENABLE][0] = ($urandom_range(9, 0) != 0);
        end
        if ($urandom_range(3, 0) == 0)
            write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_MAX, NUM_REGS)), 48'({$urandom, $urandom}));
        for (int i = 0; i < NUM_REGS; i++)
            write_reg(CFG_IDX_W'(i), vals[i]);
    endtask

    // Receiver: random stalls, plus a long hold-off when asked for.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
                hold_req = 1'b0;
                holdoffs++;
            end
            result_ch.ready <= ($urandom_range(99, 0) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        ctrl_state_t got;
        ctrl_state_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = {result_ch.cooler_on, result_ch.heater_on, result_ch.dehumidifier_on,
                   result_ch.humidifier_on, result_ch.co2_valve_on, result_ch.hvac_relays};
            if (expected_outputs.size() == 0)
                report_failure($sformatf("result with nothing pending: %s", fmt_state(got)));
            else
            begin
                want = expected_outputs.pop_front();
                results_checked++;
                if (got !== want)
                    report_failure($sformatf("expected %s, got %s",
                                             fmt_state(want), fmt_state(got)));
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results pending", expected_outputs.size());
        $display("climate_hysteresis_controller_top_test failed");
        $finish;
    end

    initial
    begin
        int next_cfg;
        rst_n = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.temp_now = '0;
        sample_ch.humid_now = '0;
        sample_ch.co2_now = '0;
        sample_ch.daytime = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        hold_req = 1'b0;
        mism_count = 0;
        sets_sent = 0;
        results_checked = 0;
        reg_writes = 0;
        bad_writes = 0;
        holdoffs = 0;
        ctl_state = '0;
        ctl_cfg = '0;
        {ctl_cfg.co2_db, ctl_cfg.humid_db, ctl_cfg.temp_db} = DEADBAND_RESET;
        ctl_cfg.enable = 1'b1;
        src_idle_pct = 23;
        snk_idle_pct = 76;

        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            else
                send_sample(dir_rows[i].smp, dir_rows[i].chk, dir_rows[i].want);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin src_idle_pct = 23; snk_idle_pct = 76; end
                1:       begin src_idle_pct = 76; snk_idle_pct = 23; end
                default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
            endcase
            next_cfg = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n == next_cfg)
                begin
                    randomize_settings();
                    next_cfg = n + $urandom_range(70, 30);
                end
                // Keep offering samples while the output side is held off.
                if (n == HOLD_AT_ITEM)
                    hold_req = 1'b1;
                send_sample(random_sample(), 1'b0, ALL_OFF);
            end
        end

        sample_ch.valid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);

        $display("covered %0d sensor sets and %0d checked results over three stall profiles",
                 sets_sent, results_checked);
        $display("%0d register writes (%0d to unused indexes), %0d long output hold-offs",
                 reg_writes, bad_writes, holdoffs);
        if (mism_count == 0 && expected_outputs.size() == 0)
            $display("climate_hysteresis_controller_top_test passed");
        else
        begin
            $display("%0d mismatches", mism_count);
            $display("climate_hysteresis_controller_top_test failed");
        end
        $finish;
    end

endmodule
